/* rtl/gapt_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// gapt_pkg
// Types, sizes and codes shared by the grid agent position table modules.
// ---------------------------------------------------------------------------
package gapt_pkg;

    // Grid geometry; the side is a power of two so that a cell splits into
    // row and column by bit fields
    localparam int GRID_SIDE  = 128;
    localparam int COORD_W    = $clog2(GRID_SIDE);
    localparam int CELL_W     = 2 * COORD_W;
    localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;

    // Corner bands and the left half, on one coordinate
    localparam logic [COORD_W-1:0] BAND_LO = COORD_W'(GRID_SIDE / 8);
    localparam logic [COORD_W-1:0] BAND_HI = COORD_W'(7 * (GRID_SIDE / 8));
    localparam logic [COORD_W-1:0] HALF    = COORD_W'(GRID_SIDE / 2);

    // Default agent count
    localparam int DEFAULT_MAX_AGENTS = 256;

    // Fixed field widths of the command and result
    localparam int OP_W       = 3;
    localparam int AGENT_ID_W = 8;
    localparam int CELL_FIELD_W = 14;
    localparam int STEP_W     = 4;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PLACE = 3'd0;
    localparam logic [OP_W-1:0] OP_MOVE  = 3'd1;
    localparam logic [OP_W-1:0] OP_ERASE = 3'd2;
    localparam logic [OP_W-1:0] OP_CULL  = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic [AGENT_ID_W-1:0]   agent_id;
        logic [CELL_FIELD_W-1:0] cell_index;
        logic signed [STEP_W-1:0] step_x;
        logic signed [STEP_W-1:0] step_y;
    } cmd_t;

    typedef struct packed {
        logic [CELL_FIELD_W-1:0] agent_cell;
        logic                    agent_alive;
        logic                    changed;
        logic                    refused;
        logic                    in_corner_zone;
    } result_t;

    // One agent table entry
    typedef struct packed {
        logic              live;
        logic [CELL_W-1:0] pos;
    } agent_ent_t;

    // Memory port controls
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

endpackage
`default_nettype wire

/* rtl/gapt_agent_table.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// gapt_agent_table
// Agent entry memory, one read and one write port, registered read data.
// Per-entry valid bits make unwritten entries read as dead at cell zero.
// ---------------------------------------------------------------------------
module gapt_agent_table #(
    parameter int MAX_AGENTS = gapt_pkg::DEFAULT_MAX_AGENTS,
    parameter int AW         = $clog2(MAX_AGENTS)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire gapt_pkg::mem_ctl_t   ctl,
    input  wire logic [AW-1:0]        rd_addr,
    input  wire logic [AW-1:0]        wr_addr,
    input  wire gapt_pkg::agent_ent_t wr_data,
    output gapt_pkg::agent_ent_t      rd_data
);

    gapt_pkg::agent_ent_t mem [MAX_AGENTS];
    gapt_pkg::agent_ent_t rd_data_reg;
    logic                 rd_valid_reg;
    logic [MAX_AGENTS-1:0] valid_reg;

    // Write and read the entry array
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Track written entries and the validity of the last read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // Unwritten entries read as the reset value
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule
`default_nettype wire

/* rtl/gapt_occ_map.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// gapt_occ_map
// Occupancy bitmap held as one memory word per grid row, registered read.
// After reset a clearing pass writes every row to zero, one row a cycle.
// ---------------------------------------------------------------------------
module gapt_occ_map (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire gapt_pkg::mem_ctl_t                ctl,
    input  wire logic [gapt_pkg::COORD_W-1:0]      rd_row,
    input  wire logic [gapt_pkg::COORD_W-1:0]      wr_row,
    input  wire logic [gapt_pkg::GRID_SIDE-1:0]    wr_data,
    output logic [gapt_pkg::GRID_SIDE-1:0]         rd_data,
    output logic                                   clearing
);

    logic [gapt_pkg::GRID_SIDE-1:0] mem [gapt_pkg::GRID_SIDE];
    logic [gapt_pkg::GRID_SIDE-1:0] rd_data_reg;
    logic [gapt_pkg::COORD_W-1:0]   clr_row_reg;
    logic [gapt_pkg::COORD_W-1:0]   clr_row_next;
    logic                           clearing_reg;
    logic                           clearing_next;
    logic                           mem_wr;
    logic [gapt_pkg::COORD_W-1:0]   mem_wr_row;
    logic [gapt_pkg::GRID_SIDE-1:0] mem_wr_data;

    // Advance the clearing pass
    always_comb
    begin
        clr_row_next  = clr_row_reg;
        clearing_next = clearing_reg;
        if (clearing_reg)
        begin
            clr_row_next = clr_row_reg + 1'b1;
            if (clr_row_reg == gapt_pkg::COORD_W'(gapt_pkg::GRID_SIDE - 1))
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_row_reg  <= '0;
            clearing_reg <= 1'b1;
        end
        else
        begin
            clr_row_reg  <= clr_row_next;
            clearing_reg <= clearing_next;
        end
    end

    // Clearing pass takes the write port while it runs
    always_comb
    begin
        mem_wr      = ctl.wr_en;
        mem_wr_row  = wr_row;
        mem_wr_data = wr_data;
        if (clearing_reg)
        begin
            mem_wr      = 1'b1;
            mem_wr_row  = clr_row_reg;
            mem_wr_data = '0;
        end
    end

    // Row memory
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            mem[mem_wr_row] <= mem_wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_row];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clearing_reg;

endmodule
`default_nettype wire

/* rtl/grid_agent_position_table.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// grid_agent_position_table
// Agent cell table and grid occupancy map with place, move, erase, cull and
// query operations on one agent per command.
//
//   channel   signals               transfer
//   command   start, busy, cmd      rising edge with start high, busy low
//   result    done, result          rising edge ending the cycle done is high
//
// A command ends in S_AGENT when nothing is written (query, dead agent, own
// cell), in S_TGT when one occupancy row is written or the target is held,
// and in S_OLDWR for a relocation across rows (target row and old row each
// take a read and a write of the single occupancy write port). An agent id
// beyond the table answers from S_IDLE. After reset busy stays high while
// the occupancy rows are cleared. The result is held for one cycle only;
// the next command may be taken in the cycle the result is shown.
// ---------------------------------------------------------------------------
module grid_agent_position_table #(
    parameter int MAX_AGENTS = gapt_pkg::DEFAULT_MAX_AGENTS
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire gapt_pkg::cmd_t  cmd,
    output logic                 done,
    output gapt_pkg::result_t    result
);

    localparam int AW     = $clog2(MAX_AGENTS);
    localparam int CW     = gapt_pkg::COORD_W;
    localparam int LW     = gapt_pkg::CELL_W;
    localparam int SIDE   = gapt_pkg::GRID_SIDE;
    localparam logic [31:0] AGENT_LIMIT = 32'(MAX_AGENTS);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_AGENT = 4'b0010,
        S_TGT   = 4'b0100,
        S_OLDWR = 4'b1000
    } state_t;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_RELOC = 2'd1,
        ACT_KILL  = 2'd2
    } act_t;

    state_t               state_reg, state_next;
    act_t                 act_reg, act_next;
    gapt_pkg::cmd_t       cmd_reg, cmd_next;
    gapt_pkg::agent_ent_t ent_reg, ent_next;
    logic [LW-1:0]        tgt_reg, tgt_next;
    logic                 done_reg, done_next;
    gapt_pkg::result_t    result_reg, result_next;

    gapt_pkg::mem_ctl_t   agt_ctl;
    logic [AW-1:0]        agt_rd_addr;
    logic [AW-1:0]        agt_addr;
    gapt_pkg::agent_ent_t agt_wr_data;
    gapt_pkg::agent_ent_t agt_rd_data;

    gapt_pkg::mem_ctl_t   occ_ctl;
    logic [CW-1:0]        occ_rd_row;
    logic [CW-1:0]        occ_wr_row;
    logic [SIDE-1:0]      occ_wr_data;
    logic [SIDE-1:0]      occ_rd_data;
    logic                 occ_clearing;

    logic                 accept;
    logic                 id_ok;
    logic [CW-1:0]        cur_x, cur_y;
    logic signed [CW+1:0] nx, ny;
    logic [CW-1:0]        mv_x, mv_y;
    act_t                 act_calc;
    logic [LW-1:0]        tgt_calc;
    logic [CW-1:0]        old_row, old_col, tgt_row, tgt_col;
    logic [SIDE-1:0]      old_mask, tgt_mask;
    logic                 fin;
    gapt_pkg::agent_ent_t fin_ent;
    logic                 fin_chg, fin_ref;
    logic [CW-1:0]        fin_x, fin_y;

    gapt_agent_table #(
        .MAX_AGENTS (MAX_AGENTS),
        .AW         (AW)
    ) u_agents (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (agt_ctl),
        .rd_addr (agt_rd_addr),
        .wr_addr (agt_addr),
        .wr_data (agt_wr_data),
        .rd_data (agt_rd_data)
    );

    gapt_occ_map u_occ (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (occ_ctl),
        .rd_row   (occ_rd_row),
        .wr_row   (occ_wr_row),
        .wr_data  (occ_wr_data),
        .rd_data  (occ_rd_data),
        .clearing (occ_clearing)
    );

    assign busy   = (state_reg != S_IDLE) || occ_clearing;
    assign accept = start && !busy;
    assign id_ok  = {{(32 - gapt_pkg::AGENT_ID_W){1'b0}}, cmd.agent_id} < AGENT_LIMIT;
    assign agt_addr = AW'(cmd_reg.agent_id);

    // Decode the fresh entry and form the move target
    always_comb
    begin
        cur_x = agt_rd_data.pos[CW-1:0];
        cur_y = agt_rd_data.pos[LW-1:CW];
        nx = $signed({2'b00, cur_x}) + (CW + 2)'(cmd_reg.step_x);
        ny = $signed({2'b00, cur_y}) + (CW + 2)'(cmd_reg.step_y);
        mv_x = (nx[CW+1:CW] == 2'b00) ? nx[CW-1:0] : cur_x;
        mv_y = (ny[CW+1:CW] == 2'b00) ? ny[CW-1:0] : cur_y;
    end

    // Pick the action for the command
    always_comb
    begin
        act_calc = ACT_NONE;
        tgt_calc = LW'(cmd_reg.cell_index);
        case (cmd_reg.op)
            gapt_pkg::OP_PLACE:
            begin
                if (32'(cmd_reg.cell_index) < 32'(gapt_pkg::CELL_COUNT))
                begin
                    act_calc = ACT_RELOC;
                end
            end
            gapt_pkg::OP_MOVE:
            begin
                tgt_calc = {mv_y, mv_x};
                if (agt_rd_data.live)
                begin
                    act_calc = ACT_RELOC;
                end
            end
            gapt_pkg::OP_ERASE:
            begin
                if (agt_rd_data.live)
                begin
                    act_calc = ACT_KILL;
                end
            end
            gapt_pkg::OP_CULL:
            begin
                if (agt_rd_data.live && (cur_x < gapt_pkg::HALF))
                begin
                    act_calc = ACT_KILL;
                end
            end
            default:
            begin
                act_calc = ACT_NONE;
            end
        endcase
    end

    // Row and bit position of the old and the target cell
    always_comb
    begin
        old_row  = ent_reg.pos[LW-1:CW];
        old_col  = ent_reg.pos[CW-1:0];
        tgt_row  = tgt_reg[LW-1:CW];
        tgt_col  = tgt_reg[CW-1:0];
        old_mask = {{(SIDE - 1){1'b0}}, 1'b1} << old_col;
        tgt_mask = {{(SIDE - 1){1'b0}}, 1'b1} << tgt_col;
    end

    // Sequence the read-modify-write of both memories
    always_comb
    begin
        state_next  = state_reg;
        act_next    = act_reg;
        cmd_next    = cmd_reg;
        ent_next    = ent_reg;
        tgt_next    = tgt_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        agt_ctl     = '0;
        agt_rd_addr = AW'(cmd.agent_id);
        agt_wr_data = '0;
        occ_ctl     = '0;
        occ_rd_row  = old_row;
        occ_wr_row  = old_row;
        occ_wr_data = occ_rd_data & ~old_mask;
        fin         = 1'b0;
        fin_ent     = ent_reg;
        fin_chg     = 1'b0;
        fin_ref     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = cmd;
                    if (id_ok)
                    begin
                        agt_ctl.rd_en = 1'b1;
                        state_next    = S_AGENT;
                    end
                    else
                    begin
                        done_next   = 1'b1;
                        result_next = '0;
                    end
                end
            end
            S_AGENT:
            begin
                ent_next = agt_rd_data;
                tgt_next = tgt_calc;
                act_next = act_calc;
                case (act_calc)
                    ACT_RELOC:
                    begin
                        if (agt_rd_data.live && (agt_rd_data.pos == tgt_calc))
                        begin
                            fin     = 1'b1;
                            fin_ent = agt_rd_data;
                        end
                        else
                        begin
                            occ_ctl.rd_en = 1'b1;
                            occ_rd_row    = tgt_calc[LW-1:CW];
                            state_next    = S_TGT;
                        end
                    end
                    ACT_KILL:
                    begin
                        occ_ctl.rd_en = 1'b1;
                        occ_rd_row    = agt_rd_data.pos[LW-1:CW];
                        state_next    = S_TGT;
                    end
                    default:
                    begin
                        fin     = 1'b1;
                        fin_ent = agt_rd_data;
                    end
                endcase
            end
            S_TGT:
            begin
                if (act_reg == ACT_KILL)
                begin
                    // Free the old cell and mark the agent dead
                    occ_ctl.wr_en = 1'b1;
                    agt_ctl.wr_en = 1'b1;
                    fin           = 1'b1;
                    fin_ent       = '0;
                    fin_chg       = 1'b1;
                end
                else if (occ_rd_data[tgt_col])
                begin
                    // Drop the relocation onto a held cell
                    fin     = 1'b1;
                    fin_ref = 1'b1;
                end
                else
                begin
                    occ_ctl.wr_en    = 1'b1;
                    occ_wr_row       = tgt_row;
                    occ_wr_data      = occ_rd_data | tgt_mask;
                    agt_ctl.wr_en    = 1'b1;
                    agt_wr_data.live = 1'b1;
                    agt_wr_data.pos  = tgt_reg;
                    if (ent_reg.live && (old_row == tgt_row))
                    begin
                        occ_wr_data = (occ_rd_data | tgt_mask) & ~old_mask;
                    end
                    if (ent_reg.live && (old_row != tgt_row))
                    begin
                        // Fetch the old row for its own write
                        occ_ctl.rd_en = 1'b1;
                        state_next    = S_OLDWR;
                    end
                    else
                    begin
                        fin     = 1'b1;
                        fin_ent = agt_wr_data;
                        fin_chg = 1'b1;
                    end
                end
            end
            S_OLDWR:
            begin
                occ_ctl.wr_en = 1'b1;
                fin           = 1'b1;
                fin_ent.live  = 1'b1;
                fin_ent.pos   = tgt_reg;
                fin_chg       = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Build the result from the final entry
        fin_x = fin_ent.pos[CW-1:0];
        fin_y = fin_ent.pos[LW-1:CW];
        if (fin)
        begin
            state_next                 = S_IDLE;
            done_next                  = 1'b1;
            result_next.agent_cell     = fin_ent.live
                                       ? gapt_pkg::CELL_FIELD_W'(fin_ent.pos) : '0;
            result_next.agent_alive    = fin_ent.live;
            result_next.changed        = fin_chg;
            result_next.refused        = fin_ref;
            result_next.in_corner_zone = fin_ent.live
                && ((fin_x < gapt_pkg::BAND_LO) || (fin_x > gapt_pkg::BAND_HI))
                && ((fin_y < gapt_pkg::BAND_LO) || (fin_y > gapt_pkg::BAND_HI));
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Payload holding
    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        cmd_reg    <= cmd_next;
        ent_reg    <= ent_next;
        tgt_reg    <= tgt_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Results are only shown once the sequencer is back at rest
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result strobe outside idle");

    // No command may be taken during the occupancy clearing pass
    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        occ_clearing |-> busy)
        else $error("ready during occupancy clear");

    // A dead agent reports cell zero and no corner
    a_dead_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !result_reg.agent_alive) |->
        ((result_reg.agent_cell == '0) && !result_reg.in_corner_zone))
        else $error("dead agent with position");

    // A refused relocation changes nothing
    a_ref_nochg: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && result_reg.refused) |-> !result_reg.changed)
        else $error("refused and changed together");

    // An in-range command always enters the sequencer
    a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && id_ok) |=> (state_reg == S_AGENT))
        else $error("accepted command not sequenced");

endmodule
`default_nettype wire
